FILE: design/bdec_pkg.sv
// Shared types, constants and the power-of-ten table for the decimal ASCII converter.
`default_nettype none

package bdec_pkg;

  localparam int unsigned NumDigits = 10;
  localparam int unsigned ValueW    = 32;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned CharW     = 6;
  localparam int unsigned CntW      = 4;
  // 9 * 10^9 needs 34 bits; keep a margin so every multiple compares unsigned.
  localparam int unsigned MultW     = 36;
  localparam int unsigned DigsW     = NumDigits * DigitW;

  localparam logic [CharW-1:0] AsciiZero = 6'd48;

  // Multiples 1*P .. 9*P of the power of ten that one cell handles.
  typedef logic [8:0][MultW-1:0] bdec_row_t;

  // One item as it travels down the chain of digit cells.
  typedef struct packed {
    logic              valid;
    logic [ValueW-1:0] rest;
    logic              begun;
    logic [DigsW-1:0]  digs;   // emitted digits, newest in the low nibble
    logic [CntW-1:0]   cnt;    // number of emitted digits
  } bdec_item_t;

  // Evaluated at elaboration only: multiples of 10^(NumDigits-1-stage).
  function automatic bdec_row_t bdec_mult_row(input int unsigned stage);
    bdec_row_t        row;
    logic [MultW-1:0] p;
    p = MultW'(1);
    for (int unsigned i = 0; i < NumDigits - 1 - stage; i++) begin
      p = p * MultW'(10);
    end
    for (int unsigned j = 1; j <= 9; j++) begin
      row[j-1] = p * MultW'(j);
    end
    return row;
  endfunction

endpackage

`default_nettype wire

FILE: design/bdec_cell.sv
// One digit cell: extracts the digit for its power of ten and hands the item on.
`default_nettype none

module bdec_cell import bdec_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire bdec_row_t  mult_i,
  input  wire logic       last_i,
  input  wire bdec_item_t item_i,
  output bdec_item_t      item_o,
  input  wire logic       ready_i,
  output logic            ready_o
);

  bdec_item_t        item_q, item_d;
  logic [DigitW-1:0] digit;
  logic [MultW-1:0]  sub;
  logic              emit;

  always_comb begin
    digit = '0;
    // Compares are monotonic in j: the highest passing multiple is the digit.
    for (int unsigned j = 1; j <= 9; j++) begin
      if ({{(MultW-ValueW){1'b0}}, item_i.rest} >= mult_i[j-1]) begin
        digit = DigitW'(j);
      end
    end
    sub  = (digit == '0) ? '0 : mult_i[digit - DigitW'(1)];
    // Suppress leading zeros, but the units digit always goes out.
    emit = (digit != '0) || item_i.begun || last_i;

    item_d       = item_i;
    item_d.rest  = item_i.rest - sub[ValueW-1:0];
    item_d.begun = item_i.begun || (digit != '0);
    if (emit) begin
      item_d.digs = {item_i.digs[DigsW-DigitW-1:0], digit};
      item_d.cnt  = item_i.cnt + CntW'(1);
    end
  end

  assign ready_o = !item_q.valid || ready_i;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_q <= '0;
    end else if (ready_o) begin
      item_q <= item_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/bdec_emit.sv
// Output stage: sends the digits of one item as ASCII characters, one per cycle.
`default_nettype none

module bdec_emit import bdec_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire bdec_item_t item_i,
  output logic            ready_o,
  output logic            strobe_o,
  output logic [CharW-1:0] digit_char_o,
  output logic            last_digit_o
);

  logic [NumDigits-1:0][DigitW-1:0] dig_q;
  logic [CntW-1:0]                  cnt_q;
  logic [DigitW-1:0]                cur;

  // Take the next item while the last character of this one goes out.
  assign ready_o = (cnt_q <= CntW'(1));

  // Digits sit right-aligned: the most significant one is at cnt_q - 1.
  assign cur          = dig_q[cnt_q - CntW'(1)];
  assign strobe_o     = (cnt_q != '0);
  assign last_digit_o = (cnt_q == CntW'(1));
  assign digit_char_o = AsciiZero + {{(CharW-DigitW){1'b0}}, cur};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (ready_o && item_i.valid) begin
      cnt_q <= item_i.cnt;
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && item_i.valid) begin
      dig_q <= item_i.digs;
    end
  end

endmodule

`default_nettype wire

FILE: design/binary_to_decimal_ascii_unit.sv
// Top level of the 32-bit binary to decimal ASCII converter.
//
// An item is taken when start is high and busy is low; it walks a chain of ten
// digit cells, one cell per power of ten from 10^9 down to 1, one cell per
// cycle unless the cell ahead is held, and its characters then leave one per
// cycle, most significant first, each marked by strobe_o, with last_digit_o on
// the final one. Leading zeros are dropped and zero gives a single '0'. The
// output port sets the pace: it takes the next item only when idle or as the
// last character of the current one goes out; the chain holds up to ten more
// items, and busy rises once it is full. The receiver cannot stall: every
// strobe is one character delivered.
`default_nettype none

module binary_to_decimal_ascii_unit import bdec_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [ValueW-1:0] value_i,
  output logic                   strobe_o,
  output logic [CharW-1:0]       digit_char_o,
  output logic                   last_digit_o
);

  bdec_item_t               items [NumDigits+1];
  bdec_item_t               in_item;
  logic [NumDigits:0]       ready;

  always_comb begin
    in_item       = '0;
    in_item.valid = start;
    in_item.rest  = value_i;
  end

  assign items[0] = in_item;

  assign busy = !ready[0];

  for (genvar k = 0; k < NumDigits; k++) begin : g_cell
    localparam bdec_row_t Row = bdec_mult_row(k);

    bdec_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .mult_i  (Row),
      .last_i  (1'(k == NumDigits - 1)),
      .item_i  (items[k]),
      .item_o  (items[k+1]),
      .ready_i (ready[k+1]),
      .ready_o (ready[k])
    );
  end

  bdec_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (items[NumDigits]),
    .ready_o      (ready[NumDigits]),
    .strobe_o     (strobe_o),
    .digit_char_o (digit_char_o),
    .last_digit_o (last_digit_o)
  );

endmodule

`default_nettype wire

FILE: design/bdec_checker.sv
// Port-level checks on the converter's character stream, bound to the top level.
`default_nettype none

module bdec_checker import bdec_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             strobe_o,
  input wire logic [CharW-1:0] digit_char_o,
  input wire logic             last_digit_o
);

  a_last_needs_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_digit_o |-> strobe_o)
    else $error("last digit flagged without a strobe");

  a_char_is_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> (digit_char_o >= AsciiZero) && (digit_char_o <= AsciiZero + 6'd9))
    else $error("character outside '0'..'9'");

  // A run never breaks before its last digit.
  a_run_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_digit_o |=> strobe_o)
    else $error("character run broken before last digit");

  // The first character of a run of more than one is never a zero.
  a_no_leading_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_digit_o && (!$past(strobe_o) || $past(last_digit_o))
    |-> digit_char_o != AsciiZero)
    else $error("leading zero emitted");

endmodule

bind binary_to_decimal_ascii_unit bdec_checker u_bdec_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .strobe_o     (strobe_o),
  .digit_char_o (digit_char_o),
  .last_digit_o (last_digit_o)
);

`default_nettype wire

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// Testbench for the decimal ASCII converter: edge and random values checked digit by digit.

module tb_top;
  import bdec_pkg::*;

  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned NumRandom   = 200;
  localparam int unsigned QuietTail   = 40;
  localparam int unsigned DrainCycles = 32;

  localparam logic [ValueW-1:0] EdgeValues [20] = '{
    32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd101, 32'd12345,
    32'd10000000, 32'd100000000, 32'd999999999, 32'd1000000000,
    32'd1000000001, 32'd2147483648, 32'd4000000000, 32'd4294967290,
    32'd4294967295, 32'h5555_5555, 32'hAAAA_AAAA, 32'd3000000050
  };

  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             is_last;
  } dec_char_t;

  class decimal_scoreboard;
    dec_char_t   due_chars[$];
    int unsigned n_values;
    int unsigned n_chars;
    int unsigned n_errors;
    int unsigned n_zero;
    int unsigned n_ten_digit;

    // Expand one accepted value into its digit characters, most significant first.
    function void note_value(logic [ValueW-1:0] v);
      logic [ValueW-1:0] rest;
      logic [ValueW-1:0] pow;
      logic [DigitW-1:0] d;
      bit                begun;
      int unsigned       ndig;
      dec_char_t         exp_ch;
      n_values++;
      if (v == '0) begin
        n_zero++;
        exp_ch.ch      = AsciiZero;
        exp_ch.is_last = 1'b1;
        due_chars.push_back(exp_ch);
        return;
      end
      rest  = v;
      pow   = 32'd1000000000;
      begun = 1'b0;
      ndig  = 0;
      for (int k = 0; k < NumDigits; k++) begin
        d = DigitW'(rest / pow);
        if (d != '0 || begun) begin
          begun          = 1'b1;
          rest           = rest - ValueW'(d) * pow;
          exp_ch.ch      = AsciiZero + CharW'(d);
          exp_ch.is_last = (pow == ValueW'(1));
          due_chars.push_back(exp_ch);
          ndig++;
        end
        pow = pow / ValueW'(10);
      end
      if (ndig == NumDigits) n_ten_digit++;
    endfunction

    function void check_char(logic [CharW-1:0] ch, logic is_last);
      dec_char_t exp_ch;
      n_chars++;
      if (due_chars.size() == 0) begin
        n_errors++;
        $display("%0t: character with none due: expected nothing, actual char %0d last %0b",
                 $time, ch, is_last);
        return;
      end
      exp_ch = due_chars.pop_front();
      if (ch !== exp_ch.ch) begin
        n_errors++;
        $display("%0t: digit_char mismatch: expected %0d, actual %0d",
                 $time, exp_ch.ch, ch);
      end
      if (is_last !== exp_ch.is_last) begin
        n_errors++;
        $display("%0t: last_digit mismatch: expected %0b, actual %0b",
                 $time, exp_ch.is_last, is_last);
      end
    endfunction

    function int unsigned pending();
      return due_chars.size();
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [ValueW-1:0] value_i;
  logic              strobe_o;
  logic [CharW-1:0]  digit_char_o;
  logic              last_digit_o;

  decimal_scoreboard sb = new();
  int unsigned       taken_cnt   = 0;
  int unsigned       idle_cycles = 0;

  binary_to_decimal_ascii_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .value_i      (value_i),
    .strobe_o     (strobe_o),
    .digit_char_o (digit_char_o),
    .last_digit_o (last_digit_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Sample pre-edge values: take items, check characters, run the watchdog.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        sb.note_value(value_i);
        taken_cnt <= taken_cnt + 1;
      end
      if (strobe_o) sb.check_char(digit_char_o, last_digit_o);
      if ((start && !busy) || strobe_o) begin
        idle_cycles <= 0;
      end else if (idle_cycles == IdleLimit) begin
        $display("%0t: watchdog expired with %0d characters due", $time, sb.pending());
        $display("TEST FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Hold the item until taken, then maybe drop start for a random burst.
  task automatic send_value(input logic [ValueW-1:0] v, input bit allow_idle);
    int unsigned target;
    start   <= 1'b1;
    value_i <= v;
    target  = taken_cnt + 1;
    wait (taken_cnt == target);
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
  endtask

  initial begin
    int unsigned       n_digits;
    logic [63:0]       lo;
    logic [63:0]       hi;
    logic [63:0]       acc;
    logic [ValueW-1:0] v;
    rst_ni  = 1'b0;
    start   = 1'b0;
    value_i = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (EdgeValues[i]) send_value(EdgeValues[i], 1'b1);

    for (int i = 0; i < NumRandom; i++) begin
      case ($urandom_range(0, 4))
        0: v = $urandom();
        1, 2: begin
          // uniform over values of a random digit count
          n_digits = $urandom_range(1, 10);
          lo = 64'd1;
          repeat (n_digits - 1) lo = lo * 64'd10;
          hi = lo * 64'd10 - 64'd1;
          if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
          v = ValueW'(lo + (64'($urandom()) % (hi - lo + 64'd1)));
        end
        3: v = $urandom_range(0, 20);
        default: begin
          // ten digits, mostly zeros after the leading one
          acc = 64'($urandom_range(1, 3));
          repeat (9) begin
            acc = acc * 64'd10;
            if ($urandom_range(0, 2) == 0) acc = acc + 64'($urandom_range(1, 9));
          end
          v = ValueW'(acc);
        end
      endcase
      send_value(v, i < NumRandom - QuietTail);
    end
    start <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Converted %0d values (%0d zero, %0d with ten digits) into %0d characters.",
             sb.n_values, sb.n_zero, sb.n_ten_digit, sb.n_chars);
    $display("Mismatches: %0d, characters still due: %0d", sb.n_errors, sb.pending());
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
